// ===== rtl/a51kbc_pkg.sv =====
package a51kbc_pkg;

    localparam int FRAME_BITS_DEF = 228;
    localparam int WARMUP_DEF     = 100;

    localparam int BYTE_W     = 8;
    localparam int KEY_W      = 64;
    localparam int FRAME_W    = 22;
    localparam int HDR_W      = 8;
    localparam int BIF_W      = 8;
    localparam int STEP_W     = 8;
    localparam int BITCNT_W   = 3;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 64;
    localparam int KEY_IDX_W  = 6;

    localparam int R1_W = 19;
    localparam int R2_W = 22;
    localparam int R3_W = 23;

    localparam logic [KEY_W-1:0]   KEY_RST   = 64'h4E2F_4D7C_1EB8_8B3A;
    localparam logic [FRAME_W-1:0] FRAME_RST = 22'h3AB3CB;
    localparam logic [HDR_W-1:0]   HDR_RST   = 8'd34;

    localparam logic [CFG_IDX_W-1:0] CFG_SESSION_KEY  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FIRST_FRAME  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_HEADER_BYTES = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_BIT,
        ST_KEY,
        ST_FRAME,
        ST_WARM,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic              load_in;
        logic              hdr_pass;
        logic              rekey_start;
        logic              key_clock;
        logic              frame_clock;
        logic              warm_clock;
        logic              rekey_done;
        logic              key_bit;
        logic              out_load;
        logic [STEP_W-1:0] step;
    } cmd_t;

    typedef struct packed {
        logic rekey_pending;
        logic in_header;
        logic out_free;
    } stat_t;

endpackage

// ===== rtl/a51kbc_ifs.sv =====
interface a51kbc_msg_if;
    logic                            valid;
    logic                            ready;
    logic [a51kbc_pkg::BYTE_W-1:0]   data_byte;
    logic                            message_start;

    modport source (output valid, output data_byte, output message_start, input ready);
    modport sink   (input valid, input data_byte, input message_start, output ready);
endinterface

interface a51kbc_res_if;
    logic                            valid;
    logic                            ready;
    logic [a51kbc_pkg::BYTE_W-1:0]   out_byte;

    modport source (output valid, output out_byte, input ready);
    modport sink   (input valid, input out_byte, output ready);
endinterface

// ===== rtl/a51kbc_ctrl.sv =====
module a51kbc_ctrl #(
    parameter int WARMUP_CLOCKS = a51kbc_pkg::WARMUP_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  a51kbc_pkg::stat_t   stat,
    output a51kbc_pkg::cmd_t    cmd
);

    a51kbc_pkg::state_t                     state_reg, state_next;
    logic [a51kbc_pkg::STEP_W-1:0]          step_reg, step_next;
    logic [a51kbc_pkg::BITCNT_W-1:0]        bitcnt_reg, bitcnt_next;
    logic [a51kbc_pkg::STEP_W:0]            step_inc;

    assign step_inc = {1'b0, step_reg} + 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= a51kbc_pkg::ST_IDLE;
            step_reg   <= '0;
            bitcnt_reg <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            step_reg   <= step_next;
            bitcnt_reg <= bitcnt_next;
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        step_next   = step_reg;
        bitcnt_next = bitcnt_reg;
        in_ready    = 1'b0;
        cmd         = '0;
        cmd.step    = step_reg;
        case (state_reg)
            a51kbc_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load_in = 1'b1;
                    state_next  = a51kbc_pkg::ST_CHECK;
                end
            end
            a51kbc_pkg::ST_CHECK:
            begin
                bitcnt_next = '0;
                if (stat.in_header)
                begin
                    cmd.hdr_pass = 1'b1;
                    state_next   = a51kbc_pkg::ST_FINISH;
                end
                else
                begin
                    state_next = a51kbc_pkg::ST_BIT;
                end
            end
            a51kbc_pkg::ST_BIT:
            begin
                if (stat.rekey_pending)
                begin
                    cmd.rekey_start = 1'b1;
                    step_next       = '0;
                    state_next      = a51kbc_pkg::ST_KEY;
                end
                else
                begin
                    cmd.key_bit = 1'b1;
                    bitcnt_next = bitcnt_reg + 1'b1;
                    if (bitcnt_reg == '1)
                    begin
                        state_next = a51kbc_pkg::ST_FINISH;
                    end
                end
            end
            a51kbc_pkg::ST_KEY:
            begin
                cmd.key_clock = 1'b1;
                if (step_inc == (a51kbc_pkg::STEP_W+1)'(a51kbc_pkg::KEY_W))
                begin
                    step_next  = '0;
                    state_next = a51kbc_pkg::ST_FRAME;
                end
                else
                begin
                    step_next = step_inc[a51kbc_pkg::STEP_W-1:0];
                end
            end
            a51kbc_pkg::ST_FRAME:
            begin
                cmd.frame_clock = 1'b1;
                if (step_inc == (a51kbc_pkg::STEP_W+1)'(a51kbc_pkg::FRAME_W))
                begin
                    step_next = '0;
                    if (WARMUP_CLOCKS == 0)
                    begin
                        cmd.rekey_done = 1'b1;
                        state_next     = a51kbc_pkg::ST_BIT;
                    end
                    else
                    begin
                        state_next = a51kbc_pkg::ST_WARM;
                    end
                end
                else
                begin
                    step_next = step_inc[a51kbc_pkg::STEP_W-1:0];
                end
            end
            a51kbc_pkg::ST_WARM:
            begin
                cmd.warm_clock = 1'b1;
                if (step_inc == (a51kbc_pkg::STEP_W+1)'(WARMUP_CLOCKS))
                begin
                    step_next      = '0;
                    cmd.rekey_done = 1'b1;
                    state_next     = a51kbc_pkg::ST_BIT;
                end
                else
                begin
                    step_next = step_inc[a51kbc_pkg::STEP_W-1:0];
                end
            end
            a51kbc_pkg::ST_FINISH:
            begin
                if (stat.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = a51kbc_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = a51kbc_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

// ===== rtl/a51kbc_datapath.sv =====
module a51kbc_datapath #(
    parameter int FRAME_BITS = a51kbc_pkg::FRAME_BITS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [a51kbc_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [a51kbc_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  logic [a51kbc_pkg::BYTE_W-1:0]       in_data,
    input  logic                                in_start,
    input  a51kbc_pkg::cmd_t                    cmd,
    output a51kbc_pkg::stat_t                   stat,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [a51kbc_pkg::BYTE_W-1:0]       out_byte
);

    logic [a51kbc_pkg::KEY_W-1:0]   key_reg;
    logic [a51kbc_pkg::FRAME_W-1:0] first_frame_reg;
    logic [a51kbc_pkg::HDR_W-1:0]   hdr_bytes_reg;

    logic [a51kbc_pkg::R1_W-1:0]    r1_reg, r1_next;
    logic [a51kbc_pkg::R2_W-1:0]    r2_reg, r2_next;
    logic [a51kbc_pkg::R3_W-1:0]    r3_reg, r3_next;

    logic [a51kbc_pkg::FRAME_W-1:0] frame_num_reg;
    logic [a51kbc_pkg::FRAME_W-1:0] frame_idx_reg;
    logic [a51kbc_pkg::BIF_W-1:0]   bif_reg;
    logic [a51kbc_pkg::HDR_W-1:0]   hdr_cnt_reg;
    logic                           rekey_pending_reg;

    logic [a51kbc_pkg::BYTE_W-1:0]  data_reg;
    logic [a51kbc_pkg::BYTE_W-1:0]  res_reg;
    logic [a51kbc_pkg::BYTE_W-1:0]  out_byte_reg;
    logic                           out_valid_reg;

    logic                           feed_bit;
    logic                           c1, c2, c3, maj;
    logic                           ks;
    logic [a51kbc_pkg::BIF_W:0]     bif_inc;

    function automatic logic [a51kbc_pkg::R1_W-1:0] feed1(
        input logic [a51kbc_pkg::R1_W-1:0] r, input logic x);
        return {r[a51kbc_pkg::R1_W-2:0], r[18] ^ r[17] ^ r[16] ^ r[13] ^ x};
    endfunction

    function automatic logic [a51kbc_pkg::R2_W-1:0] feed2(
        input logic [a51kbc_pkg::R2_W-1:0] r, input logic x);
        return {r[a51kbc_pkg::R2_W-2:0], r[21] ^ r[20] ^ x};
    endfunction

    function automatic logic [a51kbc_pkg::R3_W-1:0] feed3(
        input logic [a51kbc_pkg::R3_W-1:0] r, input logic x);
        return {r[a51kbc_pkg::R3_W-2:0], r[22] ^ r[21] ^ r[20] ^ r[7] ^ x};
    endfunction

    assign c1  = r1_reg[8];
    assign c2  = r2_reg[10];
    assign c3  = r3_reg[10];
    assign maj = (c1 & c2) | (c1 & c3) | (c2 & c3);
    assign ks  = r1_reg[18] ^ r2_reg[21] ^ r3_reg[22];

    assign feed_bit = cmd.key_clock ? key_reg[~cmd.step[a51kbc_pkg::KEY_IDX_W-1:0]]
                                    : frame_num_reg[0];

    assign bif_inc = {1'b0, bif_reg} + 1'b1;

    always_comb
    begin
        r1_next = r1_reg;
        r2_next = r2_reg;
        r3_next = r3_reg;
        if (cmd.rekey_start)
        begin
            r1_next = '0;
            r2_next = '0;
            r3_next = '0;
        end
        else if (cmd.key_clock || cmd.frame_clock)
        begin
            r1_next = feed1(r1_reg, feed_bit);
            r2_next = feed2(r2_reg, feed_bit);
            r3_next = feed3(r3_reg, feed_bit);
        end
        else if (cmd.warm_clock || cmd.key_bit)
        begin
            if (c1 == maj) r1_next = feed1(r1_reg, 1'b0);
            if (c2 == maj) r2_next = feed2(r2_reg, 1'b0);
            if (c3 == maj) r3_next = feed3(r3_reg, 1'b0);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_reg         <= a51kbc_pkg::KEY_RST;
            first_frame_reg <= a51kbc_pkg::FRAME_RST;
            hdr_bytes_reg   <= a51kbc_pkg::HDR_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                a51kbc_pkg::CFG_SESSION_KEY:
                    key_reg <= cfg_data[a51kbc_pkg::KEY_W-1:0];
                a51kbc_pkg::CFG_FIRST_FRAME:
                    first_frame_reg <= cfg_data[a51kbc_pkg::FRAME_W-1:0];
                a51kbc_pkg::CFG_HEADER_BYTES:
                    hdr_bytes_reg <= cfg_data[a51kbc_pkg::HDR_W-1:0];
                default:
                    ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            r1_reg            <= '0;
            r2_reg            <= '0;
            r3_reg            <= '0;
            frame_idx_reg     <= '0;
            bif_reg           <= '0;
            hdr_cnt_reg       <= '0;
            rekey_pending_reg <= 1'b1;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            r1_reg <= r1_next;
            r2_reg <= r2_next;
            r3_reg <= r3_next;

            if (cmd.load_in && in_start)
            begin
                hdr_cnt_reg       <= '0;
                bif_reg           <= '0;
                frame_idx_reg     <= '0;
                rekey_pending_reg <= 1'b1;
            end

            if (cmd.hdr_pass)
            begin
                hdr_cnt_reg <= hdr_cnt_reg + 1'b1;
            end

            if (cmd.rekey_done)
            begin
                bif_reg           <= '0;
                rekey_pending_reg <= 1'b0;
            end

            if (cmd.key_bit)
            begin
                if (bif_inc >= (a51kbc_pkg::BIF_W+1)'(FRAME_BITS))
                begin
                    bif_reg           <= '0;
                    frame_idx_reg     <= frame_idx_reg + 1'b1;
                    rekey_pending_reg <= 1'b1;
                end
                else
                begin
                    bif_reg <= bif_inc[a51kbc_pkg::BIF_W-1:0];
                end
            end

            if (cmd.out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            data_reg <= in_data;
        end
        else if (cmd.key_bit)
        begin
            data_reg <= data_reg >> 1;
        end

        if (cmd.hdr_pass)
        begin
            res_reg <= data_reg;
        end
        else if (cmd.key_bit)
        begin
            res_reg <= {data_reg[0] ^ ks, res_reg[a51kbc_pkg::BYTE_W-1:1]};
        end

        if (cmd.rekey_start)
        begin
            frame_num_reg <= first_frame_reg + frame_idx_reg;
        end
        else if (cmd.frame_clock)
        begin
            frame_num_reg <= frame_num_reg >> 1;
        end

        if (cmd.out_load)
        begin
            out_byte_reg <= res_reg;
        end
    end

    assign stat.rekey_pending = rekey_pending_reg;
    assign stat.in_header     = hdr_cnt_reg < hdr_bytes_reg;
    assign stat.out_free      = !out_valid_reg || out_ready;

    assign out_valid = out_valid_reg;
    assign out_byte  = out_byte_reg;

endmodule

// ===== rtl/a51_keystream_byte_cipher_top.sv =====
// A header byte goes whole, and an encrypted byte bit by bit, from the input register
// into the result register, then into the output register once that is free. A new byte
// is taken only after the previous one is in the output register; the LFSR datapath
// yields one keystream bit per clock while no rekey is pending, and every FRAME_BITS
// keystream bits a rekey clears it, clocks in 64 key and 22 frame bits, then warms up.
// Reset: registers take their default values, counters clear, a rekey is pending.
module a51_keystream_byte_cipher_top #(
    parameter int FRAME_BITS    = a51kbc_pkg::FRAME_BITS_DEF,
    parameter int WARMUP_CLOCKS = a51kbc_pkg::WARMUP_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [a51kbc_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [a51kbc_pkg::CFG_DATA_W-1:0]   cfg_data,
    a51kbc_msg_if.sink                          msg,
    a51kbc_res_if.source                        result
);

    a51kbc_pkg::cmd_t  cmd;
    a51kbc_pkg::stat_t stat;

    a51kbc_ctrl #(
        .WARMUP_CLOCKS (WARMUP_CLOCKS)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (msg.valid),
        .in_ready (msg.ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    a51kbc_datapath #(
        .FRAME_BITS (FRAME_BITS)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_data   (msg.data_byte),
        .in_start  (msg.message_start),
        .cmd       (cmd),
        .stat      (stat),
        .out_valid (result.valid),
        .out_ready (result.ready),
        .out_byte  (result.out_byte)
    );

endmodule

// ===== dv/a51kbc_checker.sv =====
module a51kbc_checker
    import a51kbc_pkg::*;
#(
    parameter int FRAME_BITS    = FRAME_BITS_DEF,
    parameter int WARMUP_CLOCKS = WARMUP_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    a51kbc_msg_if                 msg_mon,
    a51kbc_res_if                 res_mon,
    output int                    fail_count,
    output int                    pending,
    output int                    beats_checked,
    output int                    frames_keyed
);
    timeunit 1ns;
    timeprecision 1ps;

    logic [KEY_W-1:0]   key_reg;
    logic [FRAME_W-1:0] frame_base;
    logic [HDR_W-1:0]   hdr_len;

    logic [R1_W-1:0]    r1;
    logic [R2_W-1:0]    r2;
    logic [R3_W-1:0]    r3;
    logic [BIF_W-1:0]   bit_pos;
    logic [FRAME_W-1:0] frame_idx;
    logic [HDR_W-1:0]   hdr_cnt;
    logic               rekey_due;

    logic [BYTE_W-1:0]  expected_bytes[$];
    logic [BYTE_W-1:0]  want_byte;
    int                 errs;
    int                 checked;
    int                 frames;

    function automatic logic [R1_W-1:0] r1_shift(logic [R1_W-1:0] r, logic inb);
        return {r[R1_W-2:0], r[18] ^ r[17] ^ r[16] ^ r[13] ^ inb};
    endfunction

    function automatic logic [R2_W-1:0] r2_shift(logic [R2_W-1:0] r, logic inb);
        return {r[R2_W-2:0], r[21] ^ r[20] ^ inb};
    endfunction

    function automatic logic [R3_W-1:0] r3_shift(logic [R3_W-1:0] r, logic inb);
        return {r[R3_W-2:0], r[22] ^ r[21] ^ r[20] ^ r[7] ^ inb};
    endfunction

    function automatic void clock_all(logic inb);
        r1 = r1_shift(r1, inb);
        r2 = r2_shift(r2, inb);
        r3 = r3_shift(r3, inb);
    endfunction

    function automatic void clock_majority();
        logic c1;
        logic c2;
        logic c3;
        logic maj;
        c1  = r1[8];
        c2  = r2[10];
        c3  = r3[10];
        maj = (c1 & c2) | (c1 & c3) | (c2 & c3);
        if (c1 == maj) r1 = r1_shift(r1, 1'b0);
        if (c2 == maj) r2 = r2_shift(r2, 1'b0);
        if (c3 == maj) r3 = r3_shift(r3, 1'b0);
    endfunction

    function automatic void load_frame();
        logic [FRAME_W-1:0] fnum;
        fnum = frame_base + frame_idx;
        r1 = '0;
        r2 = '0;
        r3 = '0;
        for (int i = KEY_W - 1; i >= 0; i--)
            clock_all(key_reg[i]);
        for (int i = 0; i < FRAME_W; i++)
            clock_all(fnum[i]);
        for (int i = 0; i < WARMUP_CLOCKS; i++)
            clock_majority();
        bit_pos   = '0;
        rekey_due = 1'b0;
        frames++;
    endfunction

    function automatic logic draw_keystream_bit();
        logic ks;
        if (rekey_due)
            load_frame();
        ks = r1[R1_W-1] ^ r2[R2_W-1] ^ r3[R3_W-1];
        clock_majority();
        bit_pos = bit_pos + 1'b1;
        if (bit_pos >= FRAME_BITS)
        begin
            frame_idx = frame_idx + 1'b1;
            bit_pos   = '0;
            rekey_due = 1'b1;
        end
        return ks;
    endfunction

    function automatic logic [BYTE_W-1:0] cipher_byte(logic [BYTE_W-1:0] data, logic start);
        logic [BYTE_W-1:0] outb;
        if (start)
        begin
            hdr_cnt   = '0;
            bit_pos   = '0;
            frame_idx = '0;
            rekey_due = 1'b1;
        end
        if (hdr_cnt < hdr_len)
        begin
            if (hdr_cnt != 8'hFF)
                hdr_cnt = hdr_cnt + 1'b1;
            return data;
        end
        for (int i = 0; i < BYTE_W; i++)
            outb[i] = data[i] ^ draw_keystream_bit();
        return outb;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_reg    = KEY_RST;
            frame_base = FRAME_RST;
            hdr_len    = HDR_RST;
            r1         = '0;
            r2         = '0;
            r3         = '0;
            bit_pos    = '0;
            frame_idx  = '0;
            hdr_cnt    = '0;
            rekey_due  = 1'b1;
            expected_bytes.delete();
            errs       = 0;
            checked    = 0;
            frames     = 0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_SESSION_KEY:  key_reg    = cfg_data[KEY_W-1:0];
                    CFG_FIRST_FRAME:  frame_base = cfg_data[FRAME_W-1:0];
                    CFG_HEADER_BYTES: hdr_len    = cfg_data[HDR_W-1:0];
                    default: ;
                endcase
            end
            if (res_mon.valid && res_mon.ready)
            begin
                if (expected_bytes.size() == 0)
                begin
                    errs++;
                    $display("%0t: unexpected result beat: expected none, actual %02h",
                             $time, res_mon.out_byte);
                end
                else
                begin
                    want_byte = expected_bytes.pop_front();
                    checked++;
                    if (res_mon.out_byte !== want_byte)
                    begin
                        errs++;
                        $display("%0t: out_byte mismatch: expected %02h, actual %02h",
                                 $time, want_byte, res_mon.out_byte);
                    end
                end
            end
            if (msg_mon.valid && msg_mon.ready)
                expected_bytes.push_back(cipher_byte(msg_mon.data_byte,
                                                     msg_mon.message_start));
        end
        fail_count    <= errs;
        pending       <= expected_bytes.size();
        beats_checked <= checked;
        frames_keyed  <= frames;
    end

endmodule

// ===== dv/tb_top.sv =====
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import a51kbc_pkg::*;

    localparam int FRAME_BITS    = FRAME_BITS_DEF;
    localparam int WARMUP_CLOCKS = WARMUP_DEF;
    localparam int ITEMS_TARGET  = 1450;
    localparam int HOLD_CYCLES   = 400;
    localparam int IDLE_LIMIT    = 4000;
    localparam int DRAIN_CYCLES  = 4;
    localparam int TAIL_CYCLES   = 30;

    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    int  fail_count;
    int  pending;
    int  beats_checked;
    int  frames_keyed;
    int  items_sent;
    int  messages;
    int  settings;
    int  idle_cycles;
    bit  src_stall;
    bit  sink_stall;
    bit  hold_req;

    a51kbc_msg_if msg_bus ();
    a51kbc_res_if res_bus ();

    a51_keystream_byte_cipher_top #(
        .FRAME_BITS    (FRAME_BITS),
        .WARMUP_CLOCKS (WARMUP_CLOCKS)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .msg       (msg_bus),
        .result    (res_bus)
    );

    a51kbc_checker #(
        .FRAME_BITS    (FRAME_BITS),
        .WARMUP_CLOCKS (WARMUP_CLOCKS)
    ) checker_i (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .msg_mon       (msg_bus),
        .res_mon       (res_bus),
        .fail_count    (fail_count),
        .pending       (pending),
        .beats_checked (beats_checked),
        .frames_keyed  (frames_keyed)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [BYTE_W-1:0] pick_byte();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0) return 8'h00;
        if (r == 1) return 8'hFF;
        return BYTE_W'($urandom);
    endfunction

    function automatic int pick_len();
        int r;
        r = $urandom_range(0, 9);
        if (r < 3) return $urandom_range(1, 12);
        if (r < 9) return $urandom_range(13, 90);
        return $urandom_range(91, 160);
    endfunction

    function automatic logic [HDR_W-1:0] pick_header();
        int r;
        r = $urandom_range(0, 9);
        if (r < 3) return 8'd0;
        if (r == 3) return HDR_W'($urandom_range(1, 3));
        if (r == 4) return 8'hFF;
        return HDR_W'($urandom_range(4, 40));
    endfunction

    function automatic logic [FRAME_W-1:0] pick_frame();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0) return '0;
        if (r < 3) return 22'h3FFFFF - FRAME_W'($urandom_range(0, 2));
        return FRAME_W'($urandom);
    endfunction

    function automatic logic [KEY_W-1:0] pick_key();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0) return '0;
        if (r == 1) return '1;
        return {$urandom, $urandom};
    endfunction

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_we    <= 1'b0;
        @(posedge clk);
    endtask

    task automatic send_beat(input logic [BYTE_W-1:0] data, input logic start);
        int gap;
        gap = src_stall ? pick_gap() : 0;
        if (gap > 0)
        begin
            msg_bus.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        msg_bus.valid         <= 1'b1;
        msg_bus.data_byte     <= data;
        msg_bus.message_start <= start;
        @(posedge clk);
        while (!msg_bus.ready) @(posedge clk);
        items_sent++;
        if (start) messages++;
    endtask

    task automatic send_message(input int len, input logic open_new, input int noise_pct);
        logic start;
        for (int i = 0; i < len; i++)
        begin
            start = (i == 0) ? open_new : ($urandom_range(0, 99) < noise_pct);
            send_beat(pick_byte(), start);
        end
    endtask

    // hold off until every expected beat is back
    task automatic drain();
        msg_bus.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        settings++;
    endtask

    initial
    begin
        int gap;
        res_bus.ready <= 1'b0;
        wait (rst_n);
        @(posedge clk);
        forever
        begin
            if (hold_req)
            begin
                res_bus.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_req = 1'b0;
            end
            gap = sink_stall ? pick_gap() : 0;
            if (gap > 0)
            begin
                res_bus.ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            res_bus.ready <= 1'b1;
            @(posedge clk);
            while (!res_bus.valid) @(posedge clk);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((msg_bus.valid && msg_bus.ready) || (res_bus.valid && res_bus.ready) || cfg_we)
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("%0t: no beat moved for %0d cycles", $time, idle_cycles);
                $display("end of test: mismatches");
                $finish;
            end
        end
    end

    initial
    begin
        int nmsg;
        logic open_new;
        rst_n                 <= 1'b0;
        cfg_we                <= 1'b0;
        cfg_index             <= CFG_SESSION_KEY;
        cfg_data              <= '0;
        msg_bus.valid         <= 1'b0;
        msg_bus.data_byte     <= '0;
        msg_bus.message_start <= 1'b0;
        idle_cycles           <= 0;
        items_sent = 0;
        messages   = 0;
        settings   = 0;
        src_stall  = 1'b0;
        sink_stall = 1'b0;
        hold_req   = 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset values, first byte without a message start
        send_beat(8'h00, 1'b0);
        send_beat(8'hFF, 1'b0);
        send_beat(8'h81, 1'b1);
        drain();

        write_reg(CFG_HEADER_BYTES, 64'hFFFF_FFFF_FFFF_FF00);
        write_reg(CFG_SESSION_KEY, '0);
        write_reg(CFG_FIRST_FRAME, '1);
        write_reg(CFG_SPARE, {$urandom, $urandom});
        send_beat(8'h00, 1'b1);
        send_beat(8'hFF, 1'b0);
        send_beat(8'h55, 1'b0);
        send_beat(8'hAA, 1'b0);
        send_beat(8'h01, 1'b0);
        send_beat(8'h80, 1'b0);
        drain();

        write_reg(CFG_SESSION_KEY, '1);
        write_reg(CFG_FIRST_FRAME, 64'hFFFF_FFFF_FFC0_0000);
        write_reg(CFG_HEADER_BYTES, 64'h0000_0000_0000_0102);
        send_beat(8'h12, 1'b1);
        send_beat(8'h34, 1'b0);
        send_beat(8'hFF, 1'b0);
        send_beat(8'h00, 1'b1);
        send_beat(8'h7F, 1'b0);
        send_beat(8'hFE, 1'b0);
        drain();

        write_reg(CFG_SESSION_KEY, KEY_RST);
        write_reg(CFG_FIRST_FRAME, 64'(FRAME_RST));
        write_reg(CFG_HEADER_BYTES, '1);
        send_beat(8'h3C, 1'b1);
        send_beat(8'hC3, 1'b0);
        send_beat(8'h00, 1'b1);
        drain();

        // message longer than the largest header, which the counter range caps at 255 bytes
        src_stall  = 1'b1;
        sink_stall = 1'b1;
        write_reg(CFG_FIRST_FRAME, 64'(22'h3FFFFF));
        send_message(262, 1'b1, 0);
        drain();

        // sink stalls while the source keeps offering
        write_reg(CFG_HEADER_BYTES, '0);
        write_reg(CFG_SESSION_KEY, pick_key());
        src_stall = 1'b0;
        hold_req  = 1'b1;
        send_message(60, 1'b1, 0);
        drain();

        while (items_sent < ITEMS_TARGET)
        begin
            if ($urandom_range(0, 2) != 0)
                write_reg(CFG_SESSION_KEY, pick_key());
            if ($urandom_range(0, 2) != 0)
                write_reg(CFG_FIRST_FRAME, {32'($urandom), 10'($urandom), pick_frame()});
            if ($urandom_range(0, 2) != 0)
                write_reg(CFG_HEADER_BYTES, {32'($urandom), 24'($urandom), pick_header()});
            if ($urandom_range(0, 9) == 0)
                write_reg(CFG_SPARE, {$urandom, $urandom});
            src_stall  = ($urandom_range(0, 3) != 0);
            sink_stall = ($urandom_range(0, 3) != 0);
            nmsg = $urandom_range(1, 3);
            for (int m = 0; m < nmsg; m++)
            begin
                open_new = !(m == 0 && $urandom_range(0, 4) == 0);
                send_message(pick_len(), open_new,
                             ($urandom_range(0, 99) < 85) ? 0 : 15);
            end
            drain();
        end

        repeat (TAIL_CYCLES) @(posedge clk);
        if (pending != 0)
            $display("%0t: %0d expected result beats never arrived", $time, pending);
        $display("sent %0d bytes in %0d messages over %0d register settings, %0d beats compared",
                 items_sent, messages, settings, beats_checked);
        $display("%0d keystream frames set up, with saturated header and a long sink stall",
                 frames_keyed);
        if (fail_count == 0 && pending == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

// ===== a51_keystream_byte_cipher_top.f =====
rtl/a51kbc_pkg.sv
rtl/a51kbc_ifs.sv
rtl/a51kbc_ctrl.sv
rtl/a51kbc_datapath.sv
rtl/a51_keystream_byte_cipher_top.sv
dv/a51kbc_checker.sv
dv/tb_top.sv
